### src/cpt_pkg.sv
// Shared widths, types and payload records for the circumcircle point test pipeline.
`timescale 1ns / 1ps
package cpt_pkg;

	localparam int COORD_BITS = 12;
	localparam int DW    = COORD_BITS + 1;   // coordinate difference
	localparam int SW    = 2 * COORD_BITS;   // sum of two squares, unsigned
	localparam int SDW   = SW + 1;           // signed difference of two such sums
	localparam int DEN_W = 2 * DW + 2;       // twice the orientation determinant
	localparam int QW    = SDW + DW + 1;     // centre numerator, and its quotient magnitude
	localparam int PW    = QW + 1 + DW;      // centre coordinate times a difference
	localparam int EW    = PW + 3;           // squared distance difference

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		coord_t cx;
		coord_t cy;
		coord_t px;
		coord_t py;
	} pts_t;

	typedef struct packed {
		pts_t pts;
		logic neg_x;
		logic neg_y;
		logic degen;
	} ctx_t;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem_x;
		logic [DEN_W-1:0] rem_y;
		logic [QW-1:0]    nq_x;
		logic [QW-1:0]    nq_y;
	} div_t;

endpackage

### src/circumcircle_point_test.sv
// Top level of the circumcircle point test: front stages, pipelined divider, back stages.
`timescale 1ns / 1ps
// The pipe is 3 front stages, QW (39) divider stages and 3 back stages.
// Throughput: one word per cycle unless the output stalls; the divider retires one quotient bit per stage.
// The whole pipe advances together whenever the output register is empty or taken.
// Reset (arst_n low, asynchronous) clears every valid bit; data registers are not reset.
module circumcircle_point_test (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cpt_pkg::coord_t        vertex_a_x,
	input  cpt_pkg::coord_t        vertex_a_y,
	input  cpt_pkg::coord_t        vertex_b_x,
	input  cpt_pkg::coord_t        vertex_b_y,
	input  cpt_pkg::coord_t        vertex_c_x,
	input  cpt_pkg::coord_t        vertex_c_y,
	input  cpt_pkg::coord_t        query_x,
	input  cpt_pkg::coord_t        query_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   inside_res,
	output logic                   degenerate
);
	import cpt_pkg::*;

	logic  en;
	pts_t  pts;
	logic  v_d [QW+1];
	ctx_t  ctx_d [QW+1];
	div_t  div_d [QW+1];

	// A single advance enable: every stage moves when the last one can drain.
	// Bubbles stay in place, so a stall neither drops nor repeats a word.
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	assign pts.ax = vertex_a_x;
	assign pts.ay = vertex_a_y;
	assign pts.bx = vertex_b_x;
	assign pts.by = vertex_b_y;
	assign pts.cx = vertex_c_x;
	assign pts.cy = vertex_c_y;
	assign pts.px = query_x;
	assign pts.py = query_y;

	// Differences, squares, the doubled determinant and the centre numerators.
	cpt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (in_valid & in_ready),
		.pts_i  (pts),
		.v_o    (v_d[0]),
		.ctx_o  (ctx_d[0]),
		.div_o  (div_d[0])
	);

	// Unsigned restoring division of the numerator magnitudes, one bit per stage.
	for (genvar g = 0; g < QW; g++) begin : g_div
		cpt_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (v_d[g]),
			.ctx_i  (ctx_d[g]),
			.div_i  (div_d[g]),
			.v_o    (v_d[g+1]),
			.ctx_o  (ctx_d[g+1]),
			.div_o  (div_d[g+1])
		);
	end

	// Truncated signed centre, then the point is inside when it is strictly
	// closer to the centre than at least one vertex.
	cpt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_i      (v_d[QW]),
		.ctx_i    (ctx_d[QW]),
		.div_i    (div_d[QW]),
		.v_o      (out_valid),
		.inside_o (inside_res),
		.degen_o  (degenerate)
	);

endmodule

### src/cpt_front.sv
// Front stages: differences, squares, determinant and centre numerators, magnitudes.
`timescale 1ns / 1ps
module cpt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  cpt_pkg::pts_t pts_i,
	output logic          v_o,
	output cpt_pkg::ctx_t ctx_o,
	output cpt_pkg::div_t div_o
);
	import cpt_pkg::*;

	logic signed [DW-1:0]  dx1, dy1, dx2, dy2;
	logic signed [SDW-1:0] sa, sb, sc;
	logic signed [SDW-1:0] axw, ayw, bxw, byw, cxw, cyw;

	logic                  v_s1, v_s2;
	pts_t                  pts_s1, pts_s2;
	logic signed [DW-1:0]  dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [SDW-1:0] ds1_s1, ds2_s1;

	logic signed [DEN_W-1:0] det;
	logic signed [QW-1:0]    nx, ny;
	logic signed [DEN_W-1:0] den_s2;
	logic signed [QW-1:0]    nx_s2, ny_s2;

	always_comb begin
		dx1 = DW'(pts_i.bx) - DW'(pts_i.ax);
		dy1 = DW'(pts_i.by) - DW'(pts_i.ay);
		dx2 = DW'(pts_i.cx) - DW'(pts_i.ax);
		dy2 = DW'(pts_i.cy) - DW'(pts_i.ay);
		axw = SDW'(pts_i.ax);
		ayw = SDW'(pts_i.ay);
		bxw = SDW'(pts_i.bx);
		byw = SDW'(pts_i.by);
		cxw = SDW'(pts_i.cx);
		cyw = SDW'(pts_i.cy);
		sa = axw * axw + ayw * ayw;
		sb = bxw * bxw + byw * byw;
		sc = cxw * cxw + cyw * cyw;
	end

	always_comb begin
		det = DEN_W'(dx1_s1) * DEN_W'(dy2_s1) - DEN_W'(dy1_s1) * DEN_W'(dx2_s1);
		nx  = QW'(ds1_s1) * QW'(dy2_s1) - QW'(dy1_s1) * QW'(ds2_s1);
		ny  = QW'(dx1_s1) * QW'(ds2_s1) - QW'(ds1_s1) * QW'(dx2_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_o  <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_o  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s1 <= pts_i;
			dx1_s1 <= dx1;
			dy1_s1 <= dy1;
			dx2_s1 <= dx2;
			dy2_s1 <= dy2;
			ds1_s1 <= sb - sa;
			ds2_s1 <= sc - sa;

			pts_s2 <= pts_s1;
			den_s2 <= det <<< 1;
			nx_s2  <= nx;
			ny_s2  <= ny;

			ctx_o.pts   <= pts_s2;
			ctx_o.neg_x <= nx_s2[QW-1] ^ den_s2[DEN_W-1];
			ctx_o.neg_y <= ny_s2[QW-1] ^ den_s2[DEN_W-1];
			ctx_o.degen <= (den_s2 == '0);
			div_o.den   <= den_s2[DEN_W-1] ? DEN_W'(-den_s2) : DEN_W'(den_s2);
			div_o.rem_x <= '0;
			div_o.rem_y <= '0;
			div_o.nq_x  <= nx_s2[QW-1] ? QW'(-nx_s2) : QW'(nx_s2);
			div_o.nq_y  <= ny_s2[QW-1] ? QW'(-ny_s2) : QW'(ny_s2);
		end
	end

endmodule

### src/cpt_div_step.sv
// One registered restoring-division step for both centre coordinates.
`timescale 1ns / 1ps
module cpt_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  cpt_pkg::ctx_t ctx_i,
	input  cpt_pkg::div_t div_i,
	output logic          v_o,
	output cpt_pkg::ctx_t ctx_o,
	output cpt_pkg::div_t div_o
);
	import cpt_pkg::*;

	logic [DEN_W:0] tx, ty, dd;
	logic           gex, gey;

	always_comb begin
		dd  = {1'b0, div_i.den};
		tx  = {div_i.rem_x, div_i.nq_x[QW-1]};
		ty  = {div_i.rem_y, div_i.nq_y[QW-1]};
		gex = (tx >= dd);
		gey = (ty >= dd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	// The remainder stays below the divisor, so it fits the divisor's width.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_o       <= ctx_i;
			div_o.den   <= div_i.den;
			div_o.rem_x <= gex ? DEN_W'(tx - dd) : DEN_W'(tx);
			div_o.rem_y <= gey ? DEN_W'(ty - dd) : DEN_W'(ty);
			div_o.nq_x  <= {div_i.nq_x[QW-2:0], gex};
			div_o.nq_y  <= {div_i.nq_y[QW-2:0], gey};
		end
	end

endmodule

### src/cpt_back.sv
// Back stages: signed centre, distance differences against each vertex, result register.
`timescale 1ns / 1ps
module cpt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  cpt_pkg::ctx_t ctx_i,
	input  cpt_pkg::div_t div_i,
	output logic          v_o,
	output logic          inside_o,
	output logic          degen_o
);
	import cpt_pkg::*;

	logic signed [QW:0]     qx, qy;
	logic signed [SDW-1:0]  pxw, pyw, sp;
	logic signed [SDW-1:0]  vxw [3];
	logic signed [SDW-1:0]  vyw [3];
	coord_t                 vx [3];
	coord_t                 vy [3];
	logic signed [SDW-1:0]  sd [3];
	logic signed [DW-1:0]   ddx [3];
	logic signed [DW-1:0]   ddy [3];

	logic                   v_b1, v_b2;
	logic                   degen_b1, degen_b2;
	logic signed [QW:0]     qx_b1, qy_b1;
	logic signed [SDW-1:0]  sd_b1 [3];
	logic signed [DW-1:0]   ddx_b1 [3];
	logic signed [DW-1:0]   ddy_b1 [3];
	logic signed [SDW-1:0]  sd_b2 [3];
	logic signed [PW-1:0]   ppx_b2 [3];
	logic signed [PW-1:0]   ppy_b2 [3];

	logic signed [EW-1:0]   e [3];
	logic                   any_lt;

	always_comb begin
		qx = ctx_i.neg_x ? -$signed({1'b0, div_i.nq_x}) : $signed({1'b0, div_i.nq_x});
		qy = ctx_i.neg_y ? -$signed({1'b0, div_i.nq_y}) : $signed({1'b0, div_i.nq_y});
		vx[0] = ctx_i.pts.ax;
		vy[0] = ctx_i.pts.ay;
		vx[1] = ctx_i.pts.bx;
		vy[1] = ctx_i.pts.by;
		vx[2] = ctx_i.pts.cx;
		vy[2] = ctx_i.pts.cy;
		pxw = SDW'(ctx_i.pts.px);
		pyw = SDW'(ctx_i.pts.py);
		sp  = pxw * pxw + pyw * pyw;
		for (int i = 0; i < 3; i++) begin
			vxw[i] = SDW'(vx[i]);
			vyw[i] = SDW'(vy[i]);
			sd[i]  = sp - (vxw[i] * vxw[i] + vyw[i] * vyw[i]);
			ddx[i] = DW'(ctx_i.pts.px) - DW'(vx[i]);
			ddy[i] = DW'(ctx_i.pts.py) - DW'(vy[i]);
		end
	end

	// |C-P|^2 - |C-V|^2 = (|P|^2 - |V|^2) - 2 (cx (px-vx) + cy (py-vy)).
	always_comb begin
		any_lt = 1'b0;
		for (int i = 0; i < 3; i++) begin
			e[i] = EW'(sd_b2[i]) - ((EW'(ppx_b2[i]) + EW'(ppy_b2[i])) <<< 1);
			any_lt = any_lt | e[i][EW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_o  <= 1'b0;
		end else if (en) begin
			v_b1 <= v_i;
			v_b2 <= v_b1;
			v_o  <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_b1 <= ctx_i.degen;
			qx_b1    <= qx;
			qy_b1    <= qy;
			degen_b2 <= degen_b1;
			for (int i = 0; i < 3; i++) begin
				sd_b1[i]  <= sd[i];
				ddx_b1[i] <= ddx[i];
				ddy_b1[i] <= ddy[i];
				sd_b2[i]  <= sd_b1[i];
				ppx_b2[i] <= PW'(qx_b1) * PW'(ddx_b1[i]);
				ppy_b2[i] <= PW'(qy_b1) * PW'(ddy_b1[i]);
			end
			inside_o <= any_lt & ~degen_b2;
			degen_o  <= degen_b2;
		end
	end

endmodule
